/* sv/smx_pkg.sv */
`default_nettype none

package smx_pkg;

   localparam int MAX_LEN_DEF = 16;

   localparam int LOGIT_W = 16;
   localparam int PROB_W  = 16;
   localparam int FRAC_W  = 16;
   localparam int EXP_W   = 28;
   localparam int SUM_W   = 32;
   localparam int QUOT_W  = PROB_W + 1;
   localparam int MUL_W   = 18;
   localparam int PROD_W  = 33;

   localparam logic [EXP_W-1:0] EXP_MAX = '1;

   // log2(e) in Q16 and the 2^f polynomial coefficients (Horner order)
   localparam logic signed [MUL_W-1:0] LOG2E_Q16 = 18'sd94548;
   localparam logic signed [MUL_W-1:0] HORN_C0   = 18'sd5121;
   localparam logic [FRAC_W-1:0]       HORN_C1   = 16'd14823;
   localparam logic [FRAC_W-1:0]       HORN_C2   = 16'd45584;
   localparam logic [FRAC_W:0]         HORN_C3   = 17'd65536;

   typedef struct packed {
      logic signed [LOGIT_W-1:0] logit;
      logic                      last_element;
   } req_type;

   typedef struct packed {
      logic [PROB_W-1:0] probability;
      logic              last_result;
   } rsp_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_MUL_T,
      S_HORN1,
      S_HORN2,
      S_HORN3,
      S_SCALE,
      S_ACCUM,
      S_READ,
      S_DIV_GO,
      S_DIV_WAIT,
      S_OUT
   } state_type;

endpackage

`default_nettype wire

/* sv/smx_div.sv */
`default_nettype none

// Restoring divider, one quotient bit per cycle. Assumes dividend <= divisor,
// so QUOT_W steps cover the whole quotient of (dividend << 16) / divisor.
module smx_div (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       start,
   input  wire logic [smx_pkg::EXP_W-1:0]  dividend,
   input  wire logic [smx_pkg::SUM_W-1:0]  divisor,
   output logic                            done,
   output logic [smx_pkg::PROB_W-1:0]      quotient
);
   import smx_pkg::*;

   localparam int STEP_W = $clog2(QUOT_W);

   logic                busy_ff;
   logic                done_ff;
   logic [STEP_W-1:0]   step_ff;
   logic [SUM_W:0]      rem_ff;
   logic [SUM_W:0]      rem_in;
   logic [QUOT_W-1:0]   quot_ff;
   logic                ge;
   logic [SUM_W:0]      diff;
   logic                last_step;

   assign ge        = rem_ff >= {1'b0, divisor};
   assign diff      = ge ? (rem_ff - {1'b0, divisor}) : rem_ff;
   assign rem_in    = {diff[SUM_W-1:0], 1'b0};
   assign last_step = step_ff == STEP_W'(QUOT_W - 1);

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         done_ff <= busy_ff && last_step;
         if (start) begin
            busy_ff <= 1'b1;
            step_ff <= '0;
         end else if (busy_ff) begin
            if (last_step) begin
               busy_ff <= 1'b0;
            end
            step_ff <= step_ff + STEP_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff  <= (SUM_W+1)'(dividend);
         quot_ff <= '0;
      end else if (busy_ff) begin
         rem_ff  <= rem_in;
         quot_ff <= {quot_ff[QUOT_W-2:0], ge};
      end
   end

   assign done     = done_ff;
   // quotient of 1.0 or more (exp equals sum) clamps to all ones
   assign quotient = quot_ff[QUOT_W-1] ? '1 : quot_ff[PROB_W-1:0];

endmodule

`default_nettype wire

/* sv/softmax_vector.sv */
// Loading: each element is absorbed in order: accept, four passes through the shared
//   18x18 multiplier for log2(e) scaling and the 2^f polynomial, scale shift, accumulate.
// Each probability then goes through store read, divider start, 17 steps of the
//   bit-serial restoring divider, capture, and output, which can stall on rsp_ready.
// A new element is not accepted until the previous one is accumulated; results do not overlap.
// Reset: synchronous; clears the sequencer, running sum, count and read index; store is not cleared.
`default_nettype none

module softmax_vector #(
   parameter int MAX_LEN = smx_pkg::MAX_LEN_DEF
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire smx_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output smx_pkg::rsp_type      rsp_data
);
   import smx_pkg::*;

   localparam int CNT_W = $clog2(MAX_LEN + 1);
   localparam int IDX_W = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;

   state_type                  state_ff, state_in;
   logic signed [LOGIT_W-1:0]  x_ff;
   logic                       last_ff;
   logic [PROD_W-1:0]          prod_ff, prod_in;
   logic [FRAC_W-1:0]          f_ff;
   logic signed [4:0]          n_ff;
   logic [EXP_W-1:0]           e_ff, e_in;
   logic [SUM_W-1:0]           sum_ff, sum_in;
   logic [CNT_W-1:0]           count_ff;
   logic [IDX_W-1:0]           idx_ff;
   logic [EXP_W-1:0]           rd_data_ff;
   rsp_type                    rsp_ff;
   logic [EXP_W-1:0]           exp_mem [MAX_LEN];

   logic signed [MUL_W-1:0]    mul_a, mul_b;
   logic signed [2*MUL_W-1:0]  mul_p;
   logic [FRAC_W-1:0]          horn;
   logic [FRAC_W-1:0]          horn_c;
   logic [FRAC_W-1:0]          p_mid;
   logic [FRAC_W:0]            p_fin;
   logic [SUM_W-1:0]           shl;
   logic [4:0]                 shr_amt;
   logic [SUM_W:0]             sum_wide;
   logic                       room;
   logic                       idx_last;
   logic                       div_start;
   logic                       div_done;
   logic [PROB_W-1:0]          div_quot;

   // ---------------- shared multiplier ----------------
   assign horn  = prod_ff[2*FRAC_W-1:FRAC_W];
   assign p_mid = horn_c + horn;

   always_comb begin
      horn_c = HORN_C1;
      mul_a  = '0;
      mul_b  = '0;
      unique case (state_ff)
         S_MUL_T: begin
            mul_a = MUL_W'(x_ff);
            mul_b = LOG2E_Q16;
         end
         S_HORN1: begin
            mul_a = HORN_C0;
            mul_b = {2'b00, prod_ff[EXP_W-1:EXP_W-FRAC_W]};
         end
         S_HORN2: begin
            horn_c = HORN_C1;
            mul_a  = {2'b00, p_mid};
            mul_b  = {2'b00, f_ff};
         end
         S_HORN3: begin
            horn_c = HORN_C2;
            mul_a  = {2'b00, p_mid};
            mul_b  = {2'b00, f_ff};
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign mul_p   = mul_a * mul_b;
   assign prod_in = mul_p[PROD_W-1:0];

   // ---------------- scale by 2^n with saturation ----------------
   assign p_fin   = HORN_C3 + {1'b0, horn};
   assign shl     = SUM_W'(p_fin) << n_ff[3:0];
   assign shr_amt = 5'(-n_ff);

   always_comb begin
      if (!n_ff[4]) begin
         e_in = (shl > SUM_W'(EXP_MAX)) ? EXP_MAX : shl[EXP_W-1:0];
      end else begin
         e_in = EXP_W'(p_fin >> shr_amt);
      end
   end

   assign sum_wide = {1'b0, sum_ff} + (SUM_W+1)'(e_ff);
   assign sum_in   = sum_wide[SUM_W] ? '1 : sum_wide[SUM_W-1:0];
   assign room     = count_ff < CNT_W'(MAX_LEN);
   assign idx_last = (CNT_W'(idx_ff) + CNT_W'(1)) == count_ff;

   // ---------------- sequencer ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      div_start = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               state_in = S_MUL_T;
            end
         end
         S_MUL_T:  state_in = S_HORN1;
         S_HORN1:  state_in = S_HORN2;
         S_HORN2:  state_in = S_HORN3;
         S_HORN3:  state_in = S_SCALE;
         S_SCALE:  state_in = S_ACCUM;
         S_ACCUM:  state_in = last_ff ? S_READ : S_IDLE;
         S_READ:   state_in = S_DIV_GO;
         S_DIV_GO: begin
            div_start = 1'b1;
            state_in  = S_DIV_WAIT;
         end
         S_DIV_WAIT: begin
            if (div_done) begin
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               state_in = rsp_ff.last_result ? S_IDLE : S_READ;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // ---------------- control registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff   <= '0;
         count_ff <= '0;
         idx_ff   <= '0;
      end else begin
         if (state_ff == S_ACCUM && room) begin
            sum_ff   <= sum_in;
            count_ff <= count_ff + CNT_W'(1);
         end
         if (state_ff == S_ACCUM) begin
            idx_ff <= '0;
         end
         if (rsp_valid && rsp_ready) begin
            if (rsp_ff.last_result) begin
               sum_ff   <= '0;
               count_ff <= '0;
               idx_ff   <= '0;
            end else begin
               idx_ff <= idx_ff + IDX_W'(1);
            end
         end
      end
   end

   // ---------------- datapath registers ----------------
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         x_ff    <= req_data.logit;
         last_ff <= req_data.last_element;
      end
      if (state_ff == S_MUL_T || state_ff == S_HORN1 ||
          state_ff == S_HORN2 || state_ff == S_HORN3) begin
         prod_ff <= prod_in;
      end
      // t = x * log2(e): integer part n, 16-bit fraction f
      if (state_ff == S_HORN1) begin
         f_ff <= prod_ff[EXP_W-1:EXP_W-FRAC_W];
         n_ff <= prod_ff[PROD_W-1:EXP_W];
      end
      if (state_ff == S_SCALE) begin
         e_ff <= e_in;
      end
      if (state_ff == S_DIV_WAIT && div_done) begin
         rsp_ff.probability <= div_quot;
         rsp_ff.last_result <= idx_last;
      end
   end

   // ---------------- exponential store ----------------
   always_ff @(posedge clock) begin
      if (state_ff == S_ACCUM && room) begin
         exp_mem[count_ff[IDX_W-1:0]] <= e_ff;
      end
      rd_data_ff <= exp_mem[idx_ff];
   end

   smx_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (rd_data_ff),
      .divisor  (sum_ff),
      .done     (div_done),
      .quotient (div_quot)
   );

   assign rsp_data = rsp_ff;

endmodule

`default_nettype wire

/* sv/smx_chk.sv */
`default_nettype none

module smx_chk (
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             req_valid,
   input wire logic             req_ready,
   input wire logic             rsp_valid,
   input wire logic             rsp_ready,
   input wire smx_pkg::rsp_type rsp_data
);

   // a stalled result stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("rsp_valid dropped before the transaction completed");

   // no new element while a result is pending
   a_no_req_during_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("req_ready high while a result is pending");

   // an accepted element keeps the block busy for the next cycle
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("req_ready high right after an input transaction");

   // more results follow a non-final one
   a_more_after_mid: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_data.last_result |=> !req_ready)
      else $error("block went idle before the final result");

   // final result returns the block to idle
   a_idle_after_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_data.last_result |=> req_ready && !rsp_valid)
      else $error("block not idle after the final result");

endmodule

bind softmax_vector smx_chk u_smx_chk (.*);

`default_nettype wire
